// ===== rtl/buddy_page_allocator_assert.svh =====
// Assertion macros for the buddy page allocator.
// Depends on nothing; included by buddy_page_allocator, the module that checks its own logic.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPA_ASSERT(lbl, clk, rst_n, prop, msg)
`define BPA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/bpa_pkg.sv =====
// Shared types, constants and helpers of the buddy page allocator.
// Depends on nothing; used by every module of the block.
package bpa_pkg;

  localparam int NUM_ORDERS = 11;
  localparam int LIST_DEPTH = 64;
  localparam int PAGE_BITS  = 15;

  localparam int ORD_W     = $clog2(NUM_ORDERS);
  localparam int IDX_W     = $clog2(LIST_DEPTH);
  localparam int LEN_W     = $clog2(LIST_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_ORDERS * LIST_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int OPC_W        = 2;
  localparam int ORDER_W      = 4;
  localparam int PAGE_W       = 15;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 6;
  localparam int INIT_ORD_W   = 4;
  localparam int INIT_CNT_W   = 6;

  localparam logic [INIT_ORD_W-1:0] INIT_ORDER_RST = 4'd10;
  localparam logic [INIT_CNT_W-1:0] INIT_COUNT_RST = 6'd22;

  typedef enum logic [OPC_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_ORDER = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_ORDER = 1'd0,
    CFG_INIT_COUNT = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [ORDER_W-1:0] block_order;
    logic [PAGE_W-1:0]  block_page;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [PAGE_W-1:0]  result_page;
    logic [ORDER_W-1:0] result_order;
  } rsp_t;

  typedef enum logic [2:0] {
    LEN_HOLD,
    LEN_CLEAR,
    LEN_SET,
    LEN_INC,
    LEN_DEC
  } len_op_e;

  typedef struct packed {
    len_op_e          op;
    logic [ORD_W-1:0] idx;
    logic [LEN_W-1:0] val;
  } len_cmd_t;

  function automatic logic [ADDR_W-1:0] mem_addr(logic [ORD_W-1:0] o,
                                                 logic [IDX_W-1:0] idx);
    return ADDR_W'(ADDR_W'(o) * ADDR_W'(LIST_DEPTH) + ADDR_W'(idx));
  endfunction

  function automatic rsp_t mk_rsp(status_e st, logic [PAGE_BITS-1:0] pg,
                                  logic [ORDER_W-1:0] o);
    rsp_t r;
    r.status       = st;
    r.result_page  = (st == ST_OK) ? PAGE_W'(pg) : '0;
    r.result_order = (st == ST_OK) ? o : '0;
    return r;
  endfunction

endpackage

// ===== rtl/buddy_page_allocator.sv =====
// Top level of the buddy page allocator: sequencer, free list memory, config.
// Depends on bpa_pkg, bpa_len_file and buddy_page_allocator_assert.svh.
//
// A command beat is taken when start_i is high and busy_o is low; busy_o
// stays high until the result beat, which is shown on result_o for exactly
// one cycle with done_o high, and the receiver cannot stall it. One command
// is processed at a time by a small sequencer around a free list memory with
// one write port and one registered read port (one write and one registered
// read per cycle), so the cost of a command is set by those memory ports.
// Allocate scans upward over the empty orders and splits the block it finds
// down one level at a time. Free reads list entries while it looks for the
// buddy at each order, then shifts the tail of each list that loses a buddy
// down entry by entry. Lists are held with the head at the highest
// occupied slot, so pushing onto the head and popping it cost a single
// memory access. The list memory needs no clearing pass: only slots below
// a list's length are ever read, and lengths are cleared by reset.
// Configuration (init_order, init_count) is written through cfg_we_i /
// cfg_idx_i / cfg_wdata_i; the user must write it only while the block is
// idle, and the block itself does not enforce this.
`include "buddy_page_allocator_assert.svh"

module buddy_page_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  bpa_pkg::req_t                      in_data_i,
  output logic                               done_o,
  output bpa_pkg::rsp_t                      result_o,
  input  logic                               cfg_we_i,
  input  logic [bpa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bpa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INIT_WR,
    S_AL_SCAN,
    S_AL_HEAD,
    S_AL_SPLIT,
    S_AL_PUSH,
    S_FR_ORD,
    S_FR_RD,
    S_FR_CMP,
    S_FR_CHK,
    S_FR_RMO,
    S_FR_SRD,
    S_FR_SWR
  } state_e;

  state_e state_q, state_d;
  bpa_pkg::req_t req_q, req_d;
  bpa_pkg::rsp_t res_q, res_d;
  logic done_q, done_d;

  logic [bpa_pkg::INIT_ORD_W-1:0] init_order_q;
  logic [bpa_pkg::INIT_CNT_W-1:0] init_count_q;

  // o_q is the order under work, ord_q the requested one, fo_q the final
  // merged order of a free. j_q walks list slots and can hold a length.
  logic [bpa_pkg::ORD_W-1:0]     o_q, o_d, ord_q, ord_d, fo_q, fo_d;
  logic [bpa_pkg::LEN_W-1:0]     j_q, j_d;
  logic [bpa_pkg::PAGE_BITS-1:0] p_q, p_d;
  logic [bpa_pkg::IDX_W-1:0]     pos_q [bpa_pkg::NUM_ORDERS];
  logic [bpa_pkg::IDX_W-1:0]     pos_d [bpa_pkg::NUM_ORDERS];

  // Free list memory, one row of LIST_DEPTH slots per order.
  logic [bpa_pkg::PAGE_BITS-1:0] mem_q [bpa_pkg::MEM_DEPTH];
  logic [bpa_pkg::PAGE_BITS-1:0] rdata_q;
  logic                          mem_we;
  logic [bpa_pkg::ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [bpa_pkg::PAGE_BITS-1:0] mem_wdata;

  bpa_pkg::len_cmd_t         len_cmd;
  logic [bpa_pkg::LEN_W-1:0] len;

  logic [bpa_pkg::PAGE_BITS-1:0] bud;
  logic [bpa_pkg::LEN_W-1:0]     init_n;
  logic                          init_over;

  bpa_len_file u_len (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (len_cmd),
    .len_o  (len)
  );

  // The buddy of the block at the current order differs in one address bit.
  assign bud = p_q ^ (bpa_pkg::PAGE_BITS'(1) << o_q);

  // Init never loads more blocks than one list can hold.
  assign init_over = 32'(init_count_q) > 32'(bpa_pkg::LIST_DEPTH);
  assign init_n    = init_over ? bpa_pkg::LEN_W'(bpa_pkg::LIST_DEPTH)
                               : bpa_pkg::LEN_W'(init_count_q);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    res_d     = res_q;
    done_d    = 1'b0;
    o_d       = o_q;
    ord_d     = ord_q;
    fo_d      = fo_q;
    j_d       = j_q;
    p_d       = p_q;
    pos_d     = pos_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    len_cmd.op  = bpa_pkg::LEN_HOLD;
    len_cmd.idx = o_q;
    len_cmd.val = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = in_data_i;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        case (req_q.opcode)
          bpa_pkg::OP_INIT: begin
            if (32'(init_order_q) >= 32'(bpa_pkg::NUM_ORDERS)) begin
              res_d   = bpa_pkg::mk_rsp(bpa_pkg::ST_BAD_ORDER, '0, '0);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              len_cmd.op = bpa_pkg::LEN_CLEAR;
              o_d        = bpa_pkg::ORD_W'(init_order_q);
              j_d        = '0;
              state_d    = S_INIT_WR;
            end
          end
          bpa_pkg::OP_ALLOC, bpa_pkg::OP_FREE: begin
            if (32'(req_q.block_order) >= 32'(bpa_pkg::NUM_ORDERS)) begin
              res_d   = bpa_pkg::mk_rsp(bpa_pkg::ST_BAD_ORDER, '0, '0);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              o_d   = bpa_pkg::ORD_W'(req_q.block_order);
              ord_d = bpa_pkg::ORD_W'(req_q.block_order);
              p_d   = bpa_pkg::PAGE_BITS'(req_q.block_page);
              state_d = (req_q.opcode == bpa_pkg::OP_ALLOC) ? S_AL_SCAN : S_FR_ORD;
            end
          end
          default: begin
            // The unused opcode changes nothing and reports success.
            res_d   = bpa_pkg::mk_rsp(bpa_pkg::ST_OK, '0, '0);
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      // Block i goes to logical position i, which sits at slot n-1-i.
      S_INIT_WR: begin
        if (j_q == init_n) begin
          len_cmd.op  = bpa_pkg::LEN_SET;
          len_cmd.val = init_n;
          res_d  = bpa_pkg::mk_rsp(init_over ? bpa_pkg::ST_LIST_FULL : bpa_pkg::ST_OK,
                                   '0, init_order_q);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = bpa_pkg::mem_addr(o_q, bpa_pkg::IDX_W'(init_n - j_q - 1'b1));
          mem_wdata = bpa_pkg::PAGE_BITS'(j_q) << o_q;
          j_d       = j_q + 1'b1;
        end
      end

      S_AL_SCAN: begin
        if (len != '0) begin
          mem_raddr  = bpa_pkg::mem_addr(o_q, bpa_pkg::IDX_W'(len - 1'b1));
          len_cmd.op = bpa_pkg::LEN_DEC;
          state_d    = S_AL_HEAD;
        end else if (o_q == bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS - 1)) begin
          res_d   = bpa_pkg::mk_rsp(bpa_pkg::ST_NO_FREE, '0, '0);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          o_d = o_q + 1'b1;
        end
      end

      S_AL_HEAD: begin
        p_d     = rdata_q;
        state_d = S_AL_SPLIT;
      end

      S_AL_SPLIT: begin
        if (o_q == ord_q) begin
          res_d   = bpa_pkg::mk_rsp(bpa_pkg::ST_OK, p_q, bpa_pkg::ORDER_W'(ord_q));
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          o_d     = o_q - 1'b1;
          state_d = S_AL_PUSH;
        end
      end

      // The upper half goes onto the head of its list.
      S_AL_PUSH: begin
        mem_we     = 1'b1;
        mem_waddr  = bpa_pkg::mem_addr(o_q, bpa_pkg::IDX_W'(len));
        mem_wdata  = p_q + (bpa_pkg::PAGE_BITS'(1) << o_q);
        len_cmd.op = bpa_pkg::LEN_INC;
        state_d    = S_AL_SPLIT;
      end

      S_FR_ORD: begin
        if (o_q == bpa_pkg::ORD_W'(bpa_pkg::NUM_ORDERS - 1) || len == '0) begin
          state_d = S_FR_CHK;
        end else begin
          j_d     = len - 1'b1;
          state_d = S_FR_RD;
        end
      end

      S_FR_RD: begin
        mem_raddr = bpa_pkg::mem_addr(o_q, bpa_pkg::IDX_W'(j_q));
        state_d   = S_FR_CMP;
      end

      // The search runs from the head, so the first hit is the one removed.
      S_FR_CMP: begin
        if (rdata_q == bud) begin
          pos_d[o_q] = bpa_pkg::IDX_W'(j_q);
          if (bud < p_q) begin
            p_d = bud;
          end
          o_d     = o_q + 1'b1;
          state_d = S_FR_ORD;
        end else if (j_q == '0) begin
          state_d = S_FR_CHK;
        end else begin
          j_d     = j_q - 1'b1;
          state_d = S_FR_RD;
        end
      end

      S_FR_CHK: begin
        if (32'(len) >= 32'(bpa_pkg::LIST_DEPTH)) begin
          res_d   = bpa_pkg::mk_rsp(bpa_pkg::ST_LIST_FULL, '0, '0);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          fo_d    = o_q;
          o_d     = ord_q;
          state_d = S_FR_RMO;
        end
      end

      S_FR_RMO: begin
        if (o_q == fo_q) begin
          mem_we     = 1'b1;
          mem_waddr  = bpa_pkg::mem_addr(o_q, bpa_pkg::IDX_W'(len));
          mem_wdata  = p_q;
          len_cmd.op = bpa_pkg::LEN_INC;
          res_d   = bpa_pkg::mk_rsp(bpa_pkg::ST_OK, p_q, bpa_pkg::ORDER_W'(fo_q));
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          j_d     = bpa_pkg::LEN_W'(pos_q[o_q]) + 1'b1;
          state_d = S_FR_SRD;
        end
      end

      // Slots above the removed buddy move down by one.
      S_FR_SRD: begin
        if (j_q == len) begin
          len_cmd.op = bpa_pkg::LEN_DEC;
          o_d        = o_q + 1'b1;
          state_d    = S_FR_RMO;
        end else begin
          mem_raddr = bpa_pkg::mem_addr(o_q, bpa_pkg::IDX_W'(j_q));
          state_d   = S_FR_SWR;
        end
      end

      S_FR_SWR: begin
        mem_we    = 1'b1;
        mem_waddr = bpa_pkg::mem_addr(o_q, bpa_pkg::IDX_W'(j_q - 1'b1));
        mem_wdata = rdata_q;
        j_d       = j_q + 1'b1;
        state_d   = S_FR_SRD;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      done_q       <= 1'b0;
      res_q        <= '0;
      req_q        <= '0;
      o_q          <= '0;
      ord_q        <= '0;
      fo_q         <= '0;
      j_q          <= '0;
      p_q          <= '0;
      pos_q        <= '{default: '0};
      init_order_q <= bpa_pkg::INIT_ORDER_RST;
      init_count_q <= bpa_pkg::INIT_COUNT_RST;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      res_q   <= res_d;
      req_q   <= req_d;
      o_q     <= o_d;
      ord_q   <= ord_d;
      fo_q    <= fo_d;
      j_q     <= j_d;
      p_q     <= p_d;
      pos_q   <= pos_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bpa_pkg::CFG_INIT_ORDER: init_order_q <= bpa_pkg::INIT_ORD_W'(cfg_wdata_i);
          bpa_pkg::CFG_INIT_COUNT: init_count_q <= bpa_pkg::INIT_CNT_W'(cfg_wdata_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `BPA_ASSERT(a_done_idle, clk_i, rst_ni, done_o |-> !busy_o, "result while busy")
  `BPA_ASSERT(a_start_busy, clk_i, rst_ni, (start_i && !busy_o) |=> busy_o,
              "accepted command did not start")
  `BPA_ASSERT(a_done_pulse, clk_i, rst_ni, done_o |=> !done_o, "result strobe held")
  `BPA_ASSERT(a_err_zero, clk_i, rst_ni,
              (done_o && result_o.status != bpa_pkg::ST_OK) |->
              (result_o.result_page == '0 && result_o.result_order == '0),
              "error result carries data")

endmodule

// ===== rtl/bpa_len_file.sv =====
// Per-order free list length registers of the buddy page allocator.
// Depends on bpa_pkg for the command struct and the sizes.
module bpa_len_file (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bpa_pkg::len_cmd_t cmd_i,
  output logic [bpa_pkg::LEN_W-1:0] len_o
);

  logic [bpa_pkg::LEN_W-1:0] len_q [bpa_pkg::NUM_ORDERS];

  // The length of the list under work is read at the command index.
  assign len_o = len_q[cmd_i.idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '{default: '0};
    end else begin
      case (cmd_i.op)
        bpa_pkg::LEN_CLEAR: len_q <= '{default: '0};
        bpa_pkg::LEN_SET:   len_q[cmd_i.idx] <= cmd_i.val;
        bpa_pkg::LEN_INC:   len_q[cmd_i.idx] <= len_q[cmd_i.idx] + 1'b1;
        bpa_pkg::LEN_DEC:   len_q[cmd_i.idx] <= len_q[cmd_i.idx] - 1'b1;
        default: ;
      endcase
    end
  end

endmodule
